// ===== hw/rtl/pf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the Playfair encryption block.
// Depends on nothing; every other file in hw/rtl refers to it by scoped names.

package pf_pkg;

    // Function codes carried by an input transaction.
    localparam logic [1:0] FUNC_KEY     = 2'd0;
    localparam logic [1:0] FUNC_END_KEY = 2'd1;
    localparam logic [1:0] FUNC_TEXT    = 2'd2;
    localparam logic [1:0] FUNC_END_MSG = 2'd3;

    localparam int SQ_SIDE     = 5;
    localparam int SQ_SIZE     = 25;
    localparam int NUM_LETTERS = 26;

    localparam logic [4:0] LET_I    = 5'd8;
    localparam logic [4:0] LET_J    = 5'd9;
    localparam logic [4:0] LET_X    = 5'd23;
    localparam logic [4:0] LET_LAST = 5'(NUM_LETTERS - 1);
    localparam logic [4:0] SQ_FULL  = 5'(SQ_SIZE);
    localparam logic [2:0] SIDE_MAX = 3'(SQ_SIDE - 1);

    // After a clear only j counts as used, so it never enters the square.
    localparam logic [NUM_LETTERS-1:0] USED_RESET = NUM_LETTERS'(1) << LET_J;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] place_t;
    typedef logic [2:0] coord_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic key_place;
        logic fill_start;
        logic fill_step;
        logic text_hold;
        logic pair_text;
        logic pair_pad;
        logic rd_a;
        logic rd_b;
        logic calc;
        logic rd_o1;
        logic rd_o2;
        logic sel_second;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       letter_ok;
        logic       square_ready;
        logic       held_valid;
        logic       walk_last;
    } status_t;

    // Row of a place in the square (place is below 25).
    function automatic coord_t place_row(input place_t p);
        coord_t r;
        if (p >= 5'd20)
            r = 3'd4;
        else if (p >= 5'd15)
            r = 3'd3;
        else if (p >= 5'd10)
            r = 3'd2;
        else if (p >= 5'd5)
            r = 3'd1;
        else
            r = 3'd0;
        return r;
    endfunction

    // Column of a place: the place less five times its row.
    function automatic coord_t place_col(input place_t p);
        coord_t r;
        place_t base;
        r    = place_row(p);
        base = {r[2:0], 2'b00} + {2'b00, r};
        return 3'(p - base);
    endfunction

    // One step along a row or column, wrapping at the edge.
    function automatic coord_t coord_inc(input coord_t x);
        return (x == SIDE_MAX) ? 3'd0 : 3'(x + 3'd1);
    endfunction

    // Row-major place of a row and column.
    function automatic place_t place_of(input coord_t r, input coord_t c);
        return {r[2:0], 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

// ===== hw/rtl/pf_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input and result transactions.
// Depends on pf_pkg for the letter type.

interface pf_item_if;
    logic             valid;
    logic             ready;
    logic [1:0]       func;
    pf_pkg::letter_t  letter;

    modport source (output valid, output func, output letter, input ready);
    modport sink   (input valid, input func, input letter, output ready);
endinterface

interface pf_result_if;
    logic             valid;
    logic             ready;
    pf_pkg::letter_t  cipher_letter;
    logic             last;

    modport source (output valid, output cipher_letter, output last, input ready);
    modport sink   (input valid, input cipher_letter, input last, output ready);
endinterface

// ===== hw/rtl/playfair_encrypt_top.sv =====
`timescale 1ns / 1ps
// Top level of the Playfair encryption block: controller and datapath joined.
// Depends on pf_pkg, pf_if (pf_item_if, pf_result_if), pf_controller and pf_datapath.
//
//   Channel  Direction  Payload                   Use
//   item     sink       func[1:0], letter[4:0]    key letters, end of key, text, end of message
//   result   source     cipher_letter[4:0], last  cipher letters, last on the second of a pair
//
// A transaction that gives no result is accepted, then decoded and acted on.
// An end of key on an unfinished square walks the alphabet, one letter per cycle, writing unused ones.
// A completed or padded digraph steps through accept, decode, two place reads, the
// cipher place calculation, two square reads and two result transactions.
// Reset clears the used marks (j alone set), fill count, ready flag and held letter; the
// square memories have no reset. A result stall holds the letter and blocks new input.

module playfair_encrypt_top
(
    input  logic               clk,
    input  logic               rst_n,
    pf_item_if.sink            item,
    pf_result_if.source        result
);

    // The controller steers the datapath with one command struct per cycle and reads back
    // a status struct; no other signals cross between the two.
    pf_pkg::cmd_t    cmd;
    pf_pkg::status_t status;

    pf_controller u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_last  (result.last),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath holds the key square, the letter places, the used marks and the held
    // letter, and presents the cipher letter of the current result transaction.
    pf_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (item.func),
        .letter        (item.letter),
        .status        (status),
        .cipher_letter (result.cipher_letter)
    );

endmodule

// ===== hw/rtl/pf_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: key square and letter place memories, used marks, held letter and pair logic.
// Depends on pf_pkg; driven by pf_controller through pf_pkg::cmd_t.

module pf_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  pf_pkg::cmd_t      cmd,
    input  logic [1:0]        func,
    input  pf_pkg::letter_t   letter,
    output pf_pkg::status_t   status,
    output pf_pkg::letter_t   cipher_letter
);

    pf_pkg::letter_t square_mem [pf_pkg::SQ_SIZE];
    pf_pkg::place_t  place_mem  [pf_pkg::NUM_LETTERS];

    logic [1:0]                      func_reg;
    pf_pkg::letter_t                 letter_reg;
    logic [pf_pkg::NUM_LETTERS-1:0]  used_reg,        used_next;
    logic [4:0]                      fill_reg,        fill_next;
    logic                            ready_reg,       ready_next;
    logic                            held_valid_reg,  held_valid_next;
    pf_pkg::letter_t                 held_letter_reg, held_letter_next;
    logic [4:0]                      walk_reg,        walk_next;
    pf_pkg::letter_t                 a_reg, a_next;
    pf_pkg::letter_t                 b_reg, b_next;
    pf_pkg::place_t                  pa_reg, pb_reg;
    pf_pkg::place_t                  addr1_reg, addr2_reg;
    pf_pkg::letter_t                 c1_reg, c2_reg;

    pf_pkg::letter_t folded;
    logic            same_as_held;
    logic            clearing;
    logic            eff_used;
    logic [4:0]      eff_fill;
    logic            do_place;
    pf_pkg::letter_t place_let;
    pf_pkg::coord_t  r1, c1, r2, c2;
    pf_pkg::place_t  addr1, addr2;

    always_comb
    begin
        folded       = (letter_reg == pf_pkg::LET_J) ? pf_pkg::LET_I : letter_reg;
        same_as_held = (held_letter_reg == folded);

        // A key letter on a finished square starts a new key in the same cycle.
        clearing  = cmd.key_place && ready_reg;
        place_let = cmd.key_place ? folded : walk_reg;
        eff_used  = clearing ? 1'b0 : used_reg[place_let];
        eff_fill  = clearing ? 5'd0 : fill_reg;
        do_place  = (cmd.key_place || cmd.fill_step) && !eff_used
                    && (eff_fill < pf_pkg::SQ_FULL);

        used_next = clearing ? pf_pkg::USED_RESET : used_reg;
        if (do_place)
        begin
            used_next = used_next | (pf_pkg::NUM_LETTERS'(1) << place_let);
        end
        fill_next = do_place ? 5'(eff_fill + 5'd1) : eff_fill;

        walk_next = walk_reg;
        if (cmd.fill_start)
            walk_next = 5'd0;
        else if (cmd.fill_step)
            walk_next = 5'(walk_reg + 5'd1);

        ready_next = ready_reg;
        if (clearing)
            ready_next = 1'b0;
        else if (cmd.fill_step && (walk_reg == pf_pkg::LET_LAST))
            ready_next = 1'b1;

        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        if (clearing)
        begin
            held_valid_next  = 1'b0;
            held_letter_next = 5'd0;
        end
        else if (cmd.text_hold)
        begin
            held_valid_next  = 1'b1;
            held_letter_next = folded;
        end
        else if (cmd.pair_text)
        begin
            // A doubled letter is split by x and stays held for the next pair.
            held_valid_next = same_as_held;
            a_next          = held_letter_reg;
            b_next          = same_as_held ? pf_pkg::LET_X : folded;
        end
        else if (cmd.pair_pad)
        begin
            held_valid_next = 1'b0;
            a_next          = held_letter_reg;
            b_next          = pf_pkg::LET_X;
        end

        r1 = pf_pkg::place_row(pa_reg);
        c1 = pf_pkg::place_col(pa_reg);
        r2 = pf_pkg::place_row(pb_reg);
        c2 = pf_pkg::place_col(pb_reg);
        if (r1 == r2)
        begin
            addr1 = pf_pkg::place_of(r1, pf_pkg::coord_inc(c1));
            addr2 = pf_pkg::place_of(r2, pf_pkg::coord_inc(c2));
        end
        else if (c1 == c2)
        begin
            addr1 = pf_pkg::place_of(pf_pkg::coord_inc(r1), c1);
            addr2 = pf_pkg::place_of(pf_pkg::coord_inc(r2), c2);
        end
        else
        begin
            addr1 = pf_pkg::place_of(r1, c2);
            addr2 = pf_pkg::place_of(r2, c1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= pf_pkg::USED_RESET;
            fill_reg        <= 5'd0;
            ready_reg       <= 1'b0;
            held_valid_reg  <= 1'b0;
            held_letter_reg <= 5'd0;
            walk_reg        <= 5'd0;
        end
        else
        begin
            used_reg        <= used_next;
            fill_reg        <= fill_next;
            ready_reg       <= ready_next;
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
            walk_reg        <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func;
            letter_reg <= letter;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        if (cmd.calc)
        begin
            addr1_reg <= addr1;
            addr2_reg <= addr2;
        end
    end

    // Memory writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (do_place)
        begin
            square_mem[eff_fill] <= place_let;
            place_mem[place_let] <= eff_fill;
        end
        if (cmd.rd_a)
            pa_reg <= place_mem[a_reg];
        if (cmd.rd_b)
            pb_reg <= place_mem[b_reg];
        if (cmd.rd_o1)
            c1_reg <= square_mem[addr1_reg];
        if (cmd.rd_o2)
            c2_reg <= square_mem[addr2_reg];
    end

    assign status.func         = func_reg;
    assign status.letter_ok    = (letter_reg <= pf_pkg::LET_LAST);
    assign status.square_ready = ready_reg;
    assign status.held_valid   = held_valid_reg;
    assign status.walk_last    = (walk_reg == pf_pkg::LET_LAST);

    assign cipher_letter = cmd.sel_second ? c2_reg : c1_reg;

endmodule

// ===== hw/rtl/pf_controller.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences key entry, square fill and digraph encryption.
// Depends on pf_pkg; commands pf_datapath through pf_pkg::cmd_t.

module pf_controller
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             result_valid,
    output logic             result_last,
    input  logic             result_ready,
    input  pf_pkg::status_t  status,
    output pf_pkg::cmd_t     cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_FILL   = 4'd2;
    localparam logic [3:0] S_RD_A   = 4'd3;
    localparam logic [3:0] S_RD_B   = 4'd4;
    localparam logic [3:0] S_CALC   = 4'd5;
    localparam logic [3:0] S_RD_O1  = 4'd6;
    localparam logic [3:0] S_RD_O2  = 4'd7;
    localparam logic [3:0] S_SEND1  = 4'd8;
    localparam logic [3:0] S_SEND2  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        item_ready   = 1'b0;
        result_valid = 1'b0;
        result_last  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
                if (item_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (status.func)
                    pf_pkg::FUNC_KEY:
                    begin
                        cmd.key_place = status.letter_ok;
                    end
                    pf_pkg::FUNC_END_KEY:
                    begin
                        if (!status.square_ready)
                        begin
                            cmd.fill_start = 1'b1;
                            state_next     = S_FILL;
                        end
                    end
                    pf_pkg::FUNC_TEXT:
                    begin
                        if (status.square_ready && status.letter_ok)
                        begin
                            if (!status.held_valid)
                                cmd.text_hold = 1'b1;
                            else
                            begin
                                cmd.pair_text = 1'b1;
                                state_next    = S_RD_A;
                            end
                        end
                    end
                    pf_pkg::FUNC_END_MSG:
                    begin
                        if (status.square_ready && status.held_valid)
                        begin
                            cmd.pair_pad = 1'b1;
                            state_next   = S_RD_A;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.walk_last)
                    state_next = S_IDLE;
            end
            S_RD_A:
            begin
                cmd.rd_a   = 1'b1;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.rd_b   = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_RD_O1;
            end
            S_RD_O1:
            begin
                cmd.rd_o1  = 1'b1;
                state_next = S_RD_O2;
            end
            S_RD_O2:
            begin
                cmd.rd_o2  = 1'b1;
                state_next = S_SEND1;
            end
            S_SEND1:
            begin
                result_valid = 1'b1;
                if (result_ready)
                    state_next = S_SEND2;
            end
            S_SEND2:
            begin
                result_valid   = 1'b1;
                result_last    = 1'b1;
                cmd.sel_second = 1'b1;
                if (result_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== dv/playfair_encrypt_checker.sv =====
`timescale 1ns / 1ps
// Self-checking monitor for the Playfair encryption block: it watches both channels,
// predicts the enciphered letters of every input transaction and compares them in order.
// Depends on pf_pkg and the channel interfaces pf_item_if and pf_result_if.

module playfair_encrypt_checker
(
    input  logic  clk,
    input  logic  rst_n,
    pf_item_if    item,
    pf_result_if  result,
    output int    fail_count,
    output int    pending
);

    import pf_pkg::*;

    typedef struct packed {
        letter_t ch;
        logic    last;
    } cipher_t;

    // Predicted copy of the key square and the text state.
    letter_t                key_grid [SQ_SIZE];
    place_t                 grid_slot [NUM_LETTERS];
    logic [NUM_LETTERS-1:0] taken;
    int                     n_placed;
    logic                   grid_done;
    logic                   have_held;
    letter_t                held;

    cipher_t cipher_q [$];

    function automatic void clear_key();
        foreach (key_grid[k])
            key_grid[k] = '0;
        foreach (grid_slot[k])
            grid_slot[k] = '0;
        taken        = '0;
        taken[LET_J] = 1'b1;
        n_placed     = 0;
        grid_done    = 1'b0;
        have_held    = 1'b0;
        held         = '0;
    endfunction

    function automatic void add_letter(input letter_t l);
        if (!taken[l] && n_placed < SQ_SIZE)
        begin
            taken[l]           = 1'b1;
            key_grid[n_placed] = l;
            grid_slot[l]       = place_t'(n_placed);
            n_placed++;
        end
    endfunction

    // Same row: shift right; same column: shift down; otherwise swap columns.
    function automatic void push_digraph(input letter_t a, input letter_t b);
        int      r1;
        int      c1;
        int      r2;
        int      c2;
        cipher_t o1;
        cipher_t o2;
        r1 = int'(grid_slot[a]) / SQ_SIDE;
        c1 = int'(grid_slot[a]) % SQ_SIDE;
        r2 = int'(grid_slot[b]) / SQ_SIDE;
        c2 = int'(grid_slot[b]) % SQ_SIDE;
        if (r1 == r2)
        begin
            o1.ch = key_grid[r1 * SQ_SIDE + (c1 + 1) % SQ_SIDE];
            o2.ch = key_grid[r2 * SQ_SIDE + (c2 + 1) % SQ_SIDE];
        end
        else if (c1 == c2)
        begin
            o1.ch = key_grid[((r1 + 1) % SQ_SIDE) * SQ_SIDE + c1];
            o2.ch = key_grid[((r2 + 1) % SQ_SIDE) * SQ_SIDE + c2];
        end
        else
        begin
            o1.ch = key_grid[r1 * SQ_SIDE + c2];
            o2.ch = key_grid[r2 * SQ_SIDE + c1];
        end
        o1.last = 1'b0;
        o2.last = 1'b1;
        cipher_q.push_back(o1);
        cipher_q.push_back(o2);
    endfunction

    function automatic void predict_cipher(input logic [1:0] fn, input letter_t raw);
        letter_t l;
        l = (raw == LET_J) ? LET_I : raw;
        case (fn)
            FUNC_KEY:
                if (raw < NUM_LETTERS)
                begin
                    if (grid_done)
                        clear_key();
                    add_letter(l);
                end
            FUNC_END_KEY:
                if (!grid_done)
                begin
                    for (int k = 0; k < NUM_LETTERS; k++)
                        add_letter(letter_t'(k));
                    grid_done = 1'b1;
                end
            FUNC_TEXT:
                if (grid_done && raw < NUM_LETTERS)
                begin
                    if (!have_held)
                    begin
                        have_held = 1'b1;
                        held      = l;
                    end
                    else if (held == l)
                        push_digraph(held, LET_X);
                    else
                    begin
                        have_held = 1'b0;
                        push_digraph(held, l);
                    end
                end
            FUNC_END_MSG:
                if (grid_done && have_held)
                begin
                    have_held = 1'b0;
                    push_digraph(held, LET_X);
                end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cipher_t want;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            clear_key();
            cipher_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (cipher_q.size() == 0)
                begin
                    $display("%0t: unexpected letter %0d (last %0b)", $time,
                             result.cipher_letter, result.last);
                    errs++;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (result.cipher_letter !== want.ch)
                    begin
                        $display("%0t: cipher_letter expected %0d, got %0d", $time,
                                 want.ch, result.cipher_letter);
                        errs++;
                    end
                    if (result.last !== want.last)
                    begin
                        $display("%0t: last expected %0b, got %0b", $time,
                                 want.last, result.last);
                        errs++;
                    end
                end
            end
            if (item.valid && item.ready)
                predict_cipher(item.func, item.letter);
            fail_count <= fail_count + errs;
            pending    <= cipher_q.size();
        end
    end

endmodule

// ===== dv/tb_playfair_encrypt_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the Playfair encryption block: clock, reset, stimulus and verdict.
// Depends on pf_pkg, pf_if, playfair_encrypt_top and playfair_encrypt_checker.

module tb_playfair_encrypt_top;

    import pf_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int TARGET_ITEMS  = 1250;
    // Worst honest gap is a sender pause, a square walk and a result stall;
    // the limit lies well above that.
    localparam int IDLE_LIMIT    = 1000;
    // Longest internal activity after the last result is the square walk.
    localparam int SETTLE_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   n_sent;
    bit   tx_burst;

    pf_item_if   item_ch ();
    pf_result_if res_ch ();

    always #HALF_PERIOD clk = ~clk;

    playfair_encrypt_top u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    playfair_encrypt_checker u_chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Presents one input transaction and returns at the edge that accepts it.
    // The valid line stays high afterwards so that a back-to-back transaction
    // needs no lowering; anything that lets time pass must lower it first.
    // Only transactions sent with counts set count towards the target.
    task automatic send_item(input logic [1:0] fn, input letter_t l, input bit counts);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.func   <= fn;
        item_ch.letter <= l;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (counts)
            n_sent++;
    endtask

    // Holds the sender off until every predicted letter has come back. The
    // checker's count is registered, so it is first read after the next edge.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One key followed by one message. Most keys are short so that the
    // alphabetical fill does most of the work, but now and then a long key
    // runs the square full before the end of key arrives. The text is biased
    // towards repeats, x, i and j so that doubled letters, double x and the
    // j fold come up often, with a little noise mixed in.
    task automatic run_session();
        int      n_key;
        int      n_text;
        int      pick;
        letter_t prev;
        letter_t l;
        tx_burst = ($urandom_range(0, 3) == 0);
        n_key = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 32) : $urandom_range(0, 10);
        for (int k = 0; k < n_key; k++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_item(FUNC_KEY, letter_t'($urandom_range(26, 31)), 1'b0);
            else if (pick == 1)
                send_item(FUNC_TEXT, letter_t'($urandom_range(0, 31)), 1'b0);
            else
                send_item(FUNC_KEY, letter_t'($urandom_range(0, 25)), 1'b1);
        end
        send_item(FUNC_END_KEY, letter_t'($urandom_range(0, 31)), 1'b1);

        n_text = $urandom_range(1, 40);
        prev   = letter_t'($urandom_range(0, 25));
        for (int k = 0; k < n_text; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_item(FUNC_END_MSG, letter_t'($urandom_range(0, 31)), 1'b1);
            else if (pick < 6)
                send_item(FUNC_END_KEY, letter_t'($urandom_range(0, 31)), 1'b0);
            else if (pick < 9)
                send_item(FUNC_TEXT, letter_t'($urandom_range(26, 31)), 1'b0);
            else
            begin
                if (pick < 24)
                    l = prev;
                else if (pick < 34)
                    l = LET_X;
                else if (pick < 39)
                    l = LET_J;
                else if (pick < 42)
                    l = LET_I;
                else
                    l = letter_t'($urandom_range(0, 25));
                send_item(FUNC_TEXT, l, 1'b1);
                prev = l;
            end
        end
        send_item(FUNC_END_MSG, letter_t'($urandom_range(0, 31)), 1'b1);
        if ($urandom_range(0, 5) == 0)
            drain_results();
    endtask

    // Result side: before each transaction the receiver stalls for a random
    // number of cycles, except in bursts where it keeps ready high throughout.
    initial
    begin
        int gap;
        int left;
        bit rx_burst;
        res_ch.ready <= 1'b0;
        rx_burst = 1'b0;
        left     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (left == 0)
            begin
                rx_burst = ($urandom_range(0, 3) == 0);
                left     = $urandom_range(10, 60);
            end
            left--;
            gap = rx_burst ? 0 : $urandom_range(0, 11);
            if (gap != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    // Watchdog: counts cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_playfair_encrypt_top NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n          <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.func   <= FUNC_KEY;
        item_ch.letter <= '0;
        tx_burst = 1'b0;
        n_sent   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Text and end of message before any square exists
        // must be ignored.
        send_item(FUNC_TEXT,    5'd0,  1'b0);
        send_item(FUNC_END_MSG, 5'd31, 1'b0);
        // Key: j folds to i, a repeated letter is skipped, an out-of-range
        // letter is dropped, and z is the highest letter. The square becomes
        //   i a z b c / d e f g h / k l m n o / p q r s t / u v w x y
        send_item(FUNC_KEY,     LET_J, 1'b1);
        send_item(FUNC_KEY,     5'd0,  1'b1);
        send_item(FUNC_KEY,     5'd0,  1'b1);
        send_item(FUNC_KEY,     5'd31, 1'b0);
        send_item(FUNC_KEY,     5'd25, 1'b1);
        send_item(FUNC_END_KEY, 5'd31, 1'b1);
        // A second end of key on a ready square does nothing.
        send_item(FUNC_END_KEY, 5'd0,  1'b0);
        // Same row (i, a), same column (i, d) and rectangle (a, f).
        send_item(FUNC_TEXT,    LET_I, 1'b1);
        send_item(FUNC_TEXT,    5'd0,  1'b1);
        send_item(FUNC_TEXT,    LET_I, 1'b1);
        send_item(FUNC_TEXT,    5'd3,  1'b1);
        send_item(FUNC_TEXT,    5'd0,  1'b1);
        send_item(FUNC_TEXT,    5'd5,  1'b1);
        // Doubled b gives b plus x and keeps b held; an out-of-range text
        // letter is ignored; end of message pads the held b with x, and a
        // further end of message has nothing to pad.
        send_item(FUNC_TEXT,    5'd1,  1'b1);
        send_item(FUNC_TEXT,    5'd1,  1'b1);
        send_item(FUNC_TEXT,    5'd30, 1'b0);
        send_item(FUNC_END_MSG, 5'd0,  1'b1);
        send_item(FUNC_END_MSG, 5'd31, 1'b1);
        // Double x gives x twice and keeps x held; j then pairs as i.
        send_item(FUNC_TEXT,    LET_X, 1'b1);
        send_item(FUNC_TEXT,    LET_X, 1'b1);
        send_item(FUNC_TEXT,    LET_J, 1'b1);
        // A held z is dropped when a new key starts on the ready square.
        send_item(FUNC_TEXT,    5'd25, 1'b1);
        send_item(FUNC_KEY,     5'd2,  1'b1);
        send_item(FUNC_END_KEY, 5'd0,  1'b1);
        send_item(FUNC_TEXT,    5'd25, 1'b1);
        send_item(FUNC_END_MSG, 5'd0,  1'b1);

        // Let the block run dry once before the random part begins.
        drain_results();

        while (n_sent < TARGET_ITEMS)
            run_session();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_playfair_encrypt_top OK");
        else
            $display("tb_playfair_encrypt_top NOT OK");
        $finish;
    end

endmodule
